// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file.
// Depends on nothing; include once per file that asserts.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property, skipped while reset is asserted.
`define CHK_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");

// Check a property at every rising edge, reset included.
`define CHK_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

// ===== src/bscu_pkg.sv =====
// Shared types, constants and helpers of the barometric compensation unit.
// No dependencies.
package bscu_pkg;

    localparam int DATA_W      = 32;
    localparam int DIV_W       = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAL_A = 2'd0,
        CFG_CAL_B = 2'd1,
        CFG_CAL_C = 2'd2,
        CFG_OSS   = 2'd3
    } t_cfg_idx;

    localparam logic [31:0] C_B6_OFFSET = 32'd4000;
    localparam logic [31:0] C_P_X1      = 32'd3038;
    localparam logic [31:0] C_P_X2      = 32'hFFFF_E343;  // -7357
    localparam logic [31:0] C_P_ROUND   = 32'd3791;
    localparam logic [31:0] C_B7_SCALE  = 32'd50000;
    localparam logic [31:0] C_SIGN      = 32'h8000_0000;
    localparam logic [31:0] C_B4_BIAS   = 32'd32768;

    // Calibration coefficients extended to 32 bits, plus the 2-bit oversampling setting.
    typedef struct packed {
        logic [31:0] ac1;
        logic [31:0] ac2;
        logic [31:0] ac3;
        logic [31:0] ac4;
        logic [31:0] ac5;
        logic [31:0] ac6;
        logic [31:0] b1;
        logic [31:0] b2;
        logic [31:0] mc;
        logic [31:0] md;
        logic [1:0]  oss;
    } t_cal;

    typedef struct packed {
        logic [31:0] x1;
        logic [31:0] up;
    } t_front_item;

    typedef struct packed {
        logic [15:0] temp;
        logic [31:0] pres;
        logic        err;
    } t_result;

    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

endpackage

// ===== src/bscu_fifo.sv =====
// Small register queue with count, used between front and back and at the output.
// Depends on nothing.
module bscu_fifo #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, r_rptr;
    logic [CNT_W-1:0] r_cnt;
    logic             w_push, w_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_pop   = i_pop && !o_empty;
    assign w_push  = i_push && (!o_full || w_pop);
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end
endmodule

// ===== src/bscu_div.sv =====
// Pipelined unsigned restoring divider, one quotient bit per stage, with sideband.
// Depends on bscu_pkg.
module bscu_div #(
    parameter int SIDE_W = 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_vld,
    input  logic [bscu_pkg::DIV_W-1:0] i_dvd,
    input  logic [bscu_pkg::DIV_W-1:0] i_dvs,
    input  logic [SIDE_W-1:0]       i_side,
    output logic                    o_vld,
    output logic [bscu_pkg::DIV_W-1:0] o_quo,
    output logic [SIDE_W-1:0]       o_side
);
    import bscu_pkg::*;

    logic [DIV_W-1:0]  s_rem  [DIV_W+1];
    logic [DIV_W-1:0]  s_dvd  [DIV_W+1];
    logic [DIV_W-1:0]  s_dvs  [DIV_W+1];
    logic [DIV_W-1:0]  s_quo  [DIV_W+1];
    logic [SIDE_W-1:0] s_side [DIV_W+1];
    logic              s_vld  [DIV_W+1];

    assign s_rem[0]  = '0;
    assign s_dvd[0]  = i_dvd;
    assign s_dvs[0]  = i_dvs;
    assign s_quo[0]  = '0;
    assign s_side[0] = i_side;
    assign s_vld[0]  = i_vld;

    for (genvar k = 0; k < DIV_W; k++) begin : g_stage
        logic [DIV_W:0]    w_part;
        logic [DIV_W:0]    w_try;
        logic              w_ge;
        logic [DIV_W-1:0]  r_rem, r_dvd, r_dvs, r_quo;
        logic [SIDE_W-1:0] r_side;
        logic              r_vld;

        assign w_part = {s_rem[k], s_dvd[k][DIV_W-1]};
        assign w_try  = w_part - {1'b0, s_dvs[k]};
        assign w_ge   = !w_try[DIV_W];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_en) begin
                r_vld <= s_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem  <= w_ge ? w_try[DIV_W-1:0] : w_part[DIV_W-1:0];
                r_dvd  <= {s_dvd[k][DIV_W-2:0], 1'b0};
                r_dvs  <= s_dvs[k];
                r_quo  <= {s_quo[k][DIV_W-2:0], w_ge};
                r_side <= s_side[k];
            end
        end

        assign s_rem[k+1]  = r_rem;
        assign s_dvd[k+1]  = r_dvd;
        assign s_dvs[k+1]  = r_dvs;
        assign s_quo[k+1]  = r_quo;
        assign s_side[k+1] = r_side;
        assign s_vld[k+1]  = r_vld;
    end

    assign o_vld  = s_vld[DIV_W];
    assign o_quo  = s_quo[DIV_W];
    assign o_side = s_side[DIV_W];
endmodule

// ===== src/bscu_front.sv =====
// Front stage: accepts raw words, forms uncompensated pressure and first temperature term.
// Depends on bscu_pkg.
module bscu_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  bscu_pkg::t_cal        i_cal,
    input  logic                  i_push,
    input  logic [15:0]           i_raw_temperature,
    input  logic [15:0]           i_raw_pressure_word,
    output logic                  o_full,
    input  logic                  i_take,
    output logic                  o_vld,
    output bscu_pkg::t_front_item o_item
);
    import bscu_pkg::*;

    logic        r_vld;
    t_front_item r_item;
    logic [31:0] w_prod;
    logic        w_acc;

    assign o_full = r_vld && !i_take;
    assign w_acc  = i_push && !o_full;
    assign w_prod = 32'((32'(i_raw_temperature) - i_cal.ac6) * i_cal.ac5);
    assign o_vld  = r_vld;
    assign o_item = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_acc) begin
            r_vld <= 1'b1;
        end else if (i_take) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_item.x1 <= 32'($signed(w_prod) >>> 15);
            r_item.up <= 32'(i_raw_pressure_word) << i_cal.oss;
        end
    end
endmodule

// ===== src/bscu_back.sv =====
// Back pipeline: temperature division, pressure terms, pressure division, final correction.
// Depends on bscu_pkg and bscu_div.
module bscu_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  bscu_pkg::t_cal        i_cal,
    input  logic                  i_en,
    input  logic                  i_vld,
    input  bscu_pkg::t_front_item i_item,
    output logic                  o_vld,
    output bscu_pkg::t_result     o_res
);
    import bscu_pkg::*;

    localparam int SIDE1_W = 66;
    localparam int SIDE2_W = 18;

    // temperature divider inputs
    logic [31:0] w_dv, w_num, w_adv, w_anum;
    logic        w_neg;
    logic [SIDE1_W-1:0] w_side1_in, w_side1;
    logic        d1_vld;
    logic [31:0] d1_quo, d1_x1, d1_up, d1_x2;
    logic        d1_neg, d1_err;

    logic [7:1]  r_va;
    logic [31:0] r1_b5, r1_up;
    logic        r1_err;
    logic [31:0] r2_b6, r2_up;
    logic [15:0] r2_t;
    logic        r2_err;
    logic [31:0] r3_sq, r3_m2, r3_m3, r3_up;
    logic [15:0] r3_t;
    logic        r3_err;
    logic [31:0] r4_x1, r4_x2, r4_m2, r4_m3, r4_up;
    logic [15:0] r4_t;
    logic        r4_err;
    logic [31:0] r5_b3, r5_x3, r5_up;
    logic [15:0] r5_t;
    logic        r5_err;
    logic [31:0] r6_b4, r6_diff;
    logic [15:0] r6_t;
    logic        r6_err;
    logic [31:0] r7_b7, r7_b4;
    logic [15:0] r7_t;
    logic        r7_err;

    logic [31:0] w_b8, w_t32, w_sx3, w_b3a, w_xp, w_b4p, w_sq, w_m2, w_m3, w_x1, w_x2;
    logic [31:0] w_dvd2;
    logic [SIDE2_W-1:0] w_side2_in, w_side2;
    logic        d2_vld;
    logic [31:0] d2_quo;

    logic [3:1]  r_vb;
    logic [31:0] q1_p, q1_a;
    logic [15:0] q1_t, q2_t, q3_t;
    logic        q1_err, q2_err, q3_err;
    logic [31:0] q2_p, q2_sq, q2_x2, q3_p, q3_x1, q3_x2;
    logic [31:0] w_pq, w_corr, w_pfin;

    // stage entering the temperature divider
    assign w_dv   = i_item.x1 + i_cal.md;
    assign w_num  = i_cal.mc << 11;
    assign w_adv  = w_dv[31] ? 32'(-w_dv) : w_dv;
    assign w_anum = w_num[31] ? 32'(-w_num) : w_num;
    assign w_neg  = w_dv[31] ^ w_num[31];
    assign w_side1_in = {i_item.x1, i_item.up, w_neg, (w_dv == '0)};

    bscu_div #(.SIDE_W(SIDE1_W)) u_div_t (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (i_en),
        .i_vld  (i_vld),
        .i_dvd  (w_anum),
        .i_dvs  (w_adv),
        .i_side (w_side1_in),
        .o_vld  (d1_vld),
        .o_quo  (d1_quo),
        .o_side (w_side1)
    );

    assign {d1_x1, d1_up, d1_neg, d1_err} = w_side1;
    assign d1_x2 = d1_neg ? 32'(-d1_quo) : d1_quo;

    assign w_b8  = r1_b5 + 32'd8;
    assign w_t32 = 32'($signed(w_b8) >>> 4);
    assign w_sq  = 32'(r2_b6 * r2_b6);
    assign w_m2  = 32'(i_cal.ac2 * r2_b6);
    assign w_m3  = 32'(i_cal.ac3 * r2_b6);
    assign w_x1  = 32'(i_cal.b2 * r3_sq);
    assign w_x2  = 32'(i_cal.b1 * r3_sq);
    assign w_sx3 = ((i_cal.ac1 << 2) + r4_x1 + r4_m2) << i_cal.oss;
    assign w_b3a = w_sx3 + 32'd2;
    assign w_xp  = r4_m3 + r4_x2 + 32'd2;
    assign w_b4p = 32'(i_cal.ac4 * (r5_x3 + C_B4_BIAS));

    // pre-scale of the pressure division keeps the doubled dividend inside 32 bits
    assign w_dvd2     = (r7_b7 < C_SIGN) ? (r7_b7 << 1) : r7_b7;
    assign w_side2_in = {r7_t, r7_err, (r7_b7 >= C_SIGN)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= '0;
        end else if (i_en) begin
            r_va <= {r_va[6:1], d1_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_b5  <= d1_x1 + d1_x2;
            r1_up  <= d1_up;
            r1_err <= d1_err;

            r2_b6  <= r1_b5 - C_B6_OFFSET;
            r2_up  <= r1_up;
            r2_err <= r1_err;
            if ($signed(w_t32) > 32'sd32767) begin
                r2_t <= 16'h7FFF;
            end else if ($signed(w_t32) < -32'sd32768) begin
                r2_t <= 16'h8000;
            end else begin
                r2_t <= w_t32[15:0];
            end

            r3_sq  <= 32'($signed(w_sq) >>> 12);
            r3_m2  <= 32'($signed(w_m2) >>> 11);
            r3_m3  <= 32'($signed(w_m3) >>> 13);
            r3_up  <= r2_up;
            r3_t   <= r2_t;
            r3_err <= r2_err;

            r4_x1  <= 32'($signed(w_x1) >>> 11);
            r4_x2  <= 32'($signed(w_x2) >>> 16);
            r4_m2  <= r3_m2;
            r4_m3  <= r3_m3;
            r4_up  <= r3_up;
            r4_t   <= r3_t;
            r4_err <= r3_err;

            r5_b3  <= 32'($signed(w_b3a) >>> 2);
            r5_x3  <= 32'($signed(w_xp) >>> 2);
            r5_up  <= r4_up;
            r5_t   <= r4_t;
            r5_err <= r4_err;

            r6_b4   <= w_b4p >> 15;
            r6_diff <= r5_up - r5_b3;
            r6_t    <= r5_t;
            r6_err  <= r5_err || ((w_b4p >> 15) == '0);

            r7_b7  <= 32'(r6_diff * (C_B7_SCALE >> i_cal.oss));
            r7_b4  <= r6_b4;
            r7_t   <= r6_t;
            r7_err <= r6_err;
        end
    end

    bscu_div #(.SIDE_W(SIDE2_W)) u_div_p (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (i_en),
        .i_vld  (r_va[7]),
        .i_dvd  (w_dvd2),
        .i_dvs  (r7_b4),
        .i_side (w_side2_in),
        .o_vld  (d2_vld),
        .o_quo  (d2_quo),
        .o_side (w_side2)
    );

    assign w_pq = w_side2[0] ? (d2_quo << 1) : d2_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= '0;
        end else if (i_en) begin
            r_vb <= {r_vb[2:1], d2_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            q1_p   <= w_pq;
            q1_a   <= 32'($signed(w_pq) >>> 8);
            q1_t   <= w_side2[SIDE2_W-1:2];
            q1_err <= w_side2[1];

            q2_p   <= q1_p;
            q2_sq  <= 32'(q1_a * q1_a);
            q2_x2  <= 32'($signed(32'(C_P_X2 * q1_p)) >>> 16);
            q2_t   <= q1_t;
            q2_err <= q1_err;

            q3_p   <= q2_p;
            q3_x1  <= 32'($signed(32'(q2_sq * C_P_X1)) >>> 16);
            q3_x2  <= q2_x2;
            q3_t   <= q2_t;
            q3_err <= q2_err;
        end
    end

    assign w_corr = q3_x1 + q3_x2 + C_P_ROUND;
    assign w_pfin = q3_p + 32'($signed(w_corr) >>> 4);

    assign o_vld      = r_vb[3];
    assign o_res.temp = q3_err ? '0 : q3_t;
    assign o_res.pres = q3_err ? '0 : w_pfin;
    assign o_res.err  = q3_err;
endmodule

// ===== src/baro_sensor_compensation_unit.sv =====
// Both dividers are 32-stage pipelines that take one quotient bit a stage.
// Throughput: one item per cycle while the back pipeline is not stalled.
// The back pipeline stalls as a whole only when the output queue is full and not popped.
// Reset: synchronous, active low; clears queues, valid bits and calibration registers.
// Top level of the barometric compensation unit; depends on bscu_pkg and all bscu_* modules.
module baro_sensor_compensation_unit #(
    parameter int QUEUE_DEPTH = bscu_pkg::QUEUE_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [15:0]                       i_raw_temperature,
    input  logic [15:0]                       i_raw_pressure_word,
    output logic                              empty,
    input  logic                              pop,
    output logic signed [15:0]                o_temperature_tenths,
    output logic signed [31:0]                o_pressure_pa,
    output logic                              o_divide_error,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [bscu_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bscu_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import bscu_pkg::*;

    localparam int ITEM_W = $bits(t_front_item);
    localparam int RES_W  = $bits(t_result);

    logic [63:0] r_cal_a, r_cal_b;
    logic [31:0] r_cal_c;
    logic [1:0]  r_oss;
    t_cal        w_cal;

    logic        f_vld, q_full, q_empty, b_en, o_q_full, b_vld;
    t_front_item f_item, q_item;
    t_result     b_res, o_res;
    logic [ITEM_W-1:0] w_q_data;
    logic [RES_W-1:0]  w_o_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_a <= '0;
            r_cal_b <= '0;
            r_cal_c <= '0;
            r_oss   <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_CAL_A: r_cal_a <= i_cfg_data;
                CFG_CAL_B: r_cal_b <= i_cfg_data;
                CFG_CAL_C: r_cal_c <= i_cfg_data[31:0];
                CFG_OSS:   r_oss   <= i_cfg_data[1:0];
                default:   r_oss   <= r_oss;
            endcase
        end
    end

    always_comb begin
        w_cal.ac1 = sx16(r_cal_a[15:0]);
        w_cal.ac2 = sx16(r_cal_a[31:16]);
        w_cal.ac3 = sx16(r_cal_a[47:32]);
        w_cal.ac4 = {16'b0, r_cal_a[63:48]};
        w_cal.ac5 = {16'b0, r_cal_b[15:0]};
        w_cal.ac6 = {16'b0, r_cal_b[31:16]};
        w_cal.b1  = sx16(r_cal_b[47:32]);
        w_cal.b2  = sx16(r_cal_b[63:48]);
        w_cal.mc  = sx16(r_cal_c[15:0]);
        w_cal.md  = sx16(r_cal_c[31:16]);
        w_cal.oss = r_oss;
    end

    bscu_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cal              (w_cal),
        .i_push             (push),
        .i_raw_temperature  (i_raw_temperature),
        .i_raw_pressure_word(i_raw_pressure_word),
        .o_full             (full),
        .i_take             (!q_full),
        .o_vld              (f_vld),
        .o_item             (f_item)
    );

    // hand over only when the front sees the transaction taken
    bscu_fifo #(.WIDTH(ITEM_W), .DEPTH(QUEUE_DEPTH)) u_mid_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (f_vld && !q_full),
        .i_data (f_item),
        .o_full (q_full),
        .i_pop  (b_en),
        .o_data (w_q_data),
        .o_empty(q_empty)
    );

    assign q_item = t_front_item'(w_q_data);

    // advance the back pipeline whenever the output queue can take its last stage
    assign b_en = !o_q_full || (pop && !empty);

    bscu_back u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cal  (w_cal),
        .i_en   (b_en),
        .i_vld  (!q_empty),
        .i_item (q_item),
        .o_vld  (b_vld),
        .o_res  (b_res)
    );

    bscu_fifo #(.WIDTH(RES_W), .DEPTH(QUEUE_DEPTH)) u_out_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (b_vld && b_en),
        .i_data (b_res),
        .o_full (o_q_full),
        .i_pop  (pop),
        .o_data (w_o_data),
        .o_empty(empty)
    );

    assign o_res                = t_result'(w_o_data);
    assign o_temperature_tenths = o_res.temp;
    assign o_pressure_pa        = o_res.pres;
    assign o_divide_error       = o_res.err;
endmodule

// ===== src/bscu_chk.sv =====
// Port-level checker for the barometric compensation unit, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module bscu_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            full,
    input logic                            empty,
    input logic                            pop,
    input logic signed [15:0]              o_temperature_tenths,
    input logic signed [31:0]              o_pressure_pa,
    input logic                            o_divide_error
);
    // a reset cycle leaves no result waiting and room for input
    `CHK_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> empty && !full)

    // a division error zeroes both measurements
    `CHK_ASSERT(a_err_zero, i_clk, i_rst_n,
        (!empty && o_divide_error) |-> (o_pressure_pa == 0 && o_temperature_tenths == 0))

    // a waiting result holds until popped
    `CHK_ASSERT(a_out_hold, i_clk, i_rst_n,
        (!empty && !pop) |=> (!empty && $stable(o_pressure_pa)
            && $stable(o_temperature_tenths) && $stable(o_divide_error)))
endmodule

bind baro_sensor_compensation_unit bscu_chk u_chk (.*);
